FILE: hdl/qrv_pkg.sv
// Shared widths for the quaternion vector rotation pipeline.
package qrv_pkg;

  localparam int VEC_W   = 24;
  localparam int QUAT_W  = 16;
  localparam int FRAC_W  = 14;

  // Axis part after optional negation keeps +2.0 exactly.
  localparam int AXIS_W  = QUAT_W + 1;
  localparam int PROD1_W = AXIS_W + VEC_W;
  localparam int RND1_W  = PROD1_W + 1 - FRAC_W;
  localparam int CRS1_W  = RND1_W + 1;
  localparam int T_W     = CRS1_W + 1;
  localparam int PROD2_W = AXIS_W + T_W;
  localparam int RND2_W  = PROD2_W + 1 - FRAC_W;
  localparam int CRS2_W  = RND2_W + 1;
  localparam int PRODW_W = QUAT_W + T_W;
  localparam int RNDW_W  = PRODW_W + 1 - FRAC_W;
  localparam int SUM_W   = CRS2_W + 2;

  localparam int HALF    = 1 << (FRAC_W - 1);

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [QUAT_W-1:0] quat_t;

endpackage

FILE: hdl/qrv_req_if.sv
// Request channel: quaternion, vector and rotation direction.
interface qrv_req_if
  import qrv_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  req_type;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  vec_t  vec_x;
  vec_t  vec_y;
  vec_t  vec_z;

  modport source (output valid, req_type, quat_x, quat_y, quat_z, quat_w,
                  vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, req_type, quat_x, quat_y, quat_z, quat_w,
                  vec_x, vec_y, vec_z, output ready);
endinterface

FILE: hdl/qrv_res_if.sv
// Result channel: rotated vector and clip flag.
interface qrv_res_if
  import qrv_pkg::*;
;
  logic valid;
  logic ready;
  vec_t out_x;
  vec_t out_y;
  vec_t out_z;
  logic saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: hdl/quaternion_rotate_vector.sv
// Quaternion vector rotation, six-stage pipeline with saturated output.
//
//   channel  dir  payload
//   req      in   req_type, quat_x/y/z/w (Q2.14), vec_x/y/z
//   res      out  out_x/y/z, saturated
//
// One request per cycle while the result side is not stalling; an accepted request
// passes through the stage registers in order and is offered from the last one.
// Stages: axis negate, a x v products, round/sub, a x t and w*t products,
// round/sum, clip to output register. Each stage holds while the next is
// full and stalled; empty stages still fill, so bubbles are squeezed out.
// Synchronous reset clears the valid bits only.
module quaternion_rotate_vector
  import qrv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  qrv_req_if.sink   req,
  qrv_res_if.source res
);

  localparam int NSTG = 6;

  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  // stage 1
  logic signed [AXIS_W-1:0]  a1 [3];
  logic signed [QUAT_W-1:0]  w1;
  logic signed [VEC_W-1:0]   v1 [3];
  // stage 2
  logic signed [AXIS_W-1:0]  a2 [3];
  logic signed [QUAT_W-1:0]  w2;
  logic signed [VEC_W-1:0]   v2 [3];
  logic signed [PROD1_W-1:0] pl2 [3];
  logic signed [PROD1_W-1:0] pr2 [3];
  // stage 3
  logic signed [AXIS_W-1:0]  a3 [3];
  logic signed [QUAT_W-1:0]  w3;
  logic signed [VEC_W-1:0]   v3 [3];
  logic signed [T_W-1:0]     t3 [3];
  // stage 4
  logic signed [VEC_W-1:0]   v4 [3];
  logic signed [PROD2_W-1:0] ql4 [3];
  logic signed [PROD2_W-1:0] qr4 [3];
  logic signed [PRODW_W-1:0] wt4 [3];
  // stage 5
  logic signed [SUM_W-1:0]   r5 [3];
  // stage 6
  logic signed [VEC_W-1:0]   o6 [3];
  logic [2:0]                clip6;

  logic signed [AXIS_W-1:0]  ain [3];
  logic signed [VEC_W-1:0]   vin [3];
  logic signed [QUAT_W-1:0]  qin [3];
  logic signed [T_W-1:0]     t_next [3];
  logic signed [SUM_W-1:0]   r_next [3];
  logic signed [VEC_W-1:0]   o_next [3];
  logic [2:0]                clip_next;

  // handshake and stage enables
  assign en[NSTG] = !vld[NSTG] || res.ready;
  genvar k;
  generate
    for (k = 1; k < NSTG; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate
  assign req.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= req.valid;
      for (int s = 2; s <= NSTG; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  assign qin[0] = req.quat_x;
  assign qin[1] = req.quat_y;
  assign qin[2] = req.quat_z;
  assign vin[0] = req.vec_x;
  assign vin[1] = req.vec_y;
  assign vin[2] = req.vec_z;

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      logic signed [PROD1_W:0]   pl_e, pr_e;
      logic signed [RND1_W-1:0]  pl_r, pr_r;
      logic signed [CRS1_W-1:0]  c;
      logic signed [PROD2_W:0]   ql_e, qr_e;
      logic signed [RND2_W-1:0]  ql_r, qr_r;
      logic signed [PRODW_W:0]   wt_e;
      logic signed [RNDW_W-1:0]  wt_r;
      logic signed [CRS2_W-1:0]  u;
      logic [SUM_W-VEC_W:0]      top;

      assign ain[i] = req.req_type ? -AXIS_W'(qin[i]) : AXIS_W'(qin[i]);

      // round to nearest, ties up: add half then arithmetic shift
      assign pl_e = {pl2[i][PROD1_W-1], pl2[i]} + (PROD1_W+1)'(HALF);
      assign pr_e = {pr2[i][PROD1_W-1], pr2[i]} + (PROD1_W+1)'(HALF);
      assign pl_r = pl_e[PROD1_W:FRAC_W];
      assign pr_r = pr_e[PROD1_W:FRAC_W];
      assign c    = CRS1_W'(pl_r) - CRS1_W'(pr_r);
      assign t_next[i] = {c, 1'b0};

      assign ql_e = {ql4[i][PROD2_W-1], ql4[i]} + (PROD2_W+1)'(HALF);
      assign qr_e = {qr4[i][PROD2_W-1], qr4[i]} + (PROD2_W+1)'(HALF);
      assign wt_e = {wt4[i][PRODW_W-1], wt4[i]} + (PRODW_W+1)'(HALF);
      assign ql_r = ql_e[PROD2_W:FRAC_W];
      assign qr_r = qr_e[PROD2_W:FRAC_W];
      assign wt_r = wt_e[PRODW_W:FRAC_W];
      assign u    = CRS2_W'(ql_r) - CRS2_W'(qr_r);
      assign r_next[i] = SUM_W'(v4[i]) + SUM_W'(wt_r) + SUM_W'(u);

      // clip: fits when the sign bit and all bits above it agree
      assign top = r5[i][SUM_W-1:VEC_W-1];
      always_comb begin
        if (top == '0 || top == '1) begin
          o_next[i]    = r5[i][VEC_W-1:0];
          clip_next[i] = 1'b0;
        end else begin
          o_next[i]    = r5[i][SUM_W-1] ? {1'b1, {(VEC_W-1){1'b0}}}
                                        : {1'b0, {(VEC_W-1){1'b1}}};
          clip_next[i] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (en[1]) begin
          a1[i] <= ain[i];
          v1[i] <= vin[i];
        end
        if (en[2]) begin
          a2[i]  <= a1[i];
          v2[i]  <= v1[i];
          pl2[i] <= PROD1_W'(a1[J]) * PROD1_W'(v1[K]);
          pr2[i] <= PROD1_W'(a1[K]) * PROD1_W'(v1[J]);
        end
        if (en[3]) begin
          a3[i] <= a2[i];
          v3[i] <= v2[i];
          t3[i] <= t_next[i];
        end
        if (en[4]) begin
          v4[i]  <= v3[i];
          ql4[i] <= PROD2_W'(a3[J]) * PROD2_W'(t3[K]);
          qr4[i] <= PROD2_W'(a3[K]) * PROD2_W'(t3[J]);
          wt4[i] <= PRODW_W'(w3) * PRODW_W'(t3[i]);
        end
        if (en[5]) begin
          r5[i] <= r_next[i];
        end
        if (en[6]) begin
          o6[i]    <= o_next[i];
          clip6[i] <= clip_next[i];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[1]) w1 <= req.quat_w;
    if (en[2]) w2 <= w1;
    if (en[3]) w3 <= w2;
  end

  assign res.valid     = vld[NSTG];
  assign res.out_x     = o6[0];
  assign res.out_y     = o6[1];
  assign res.out_z     = o6[2];
  assign res.saturated = |clip6;

endmodule

FILE: test/quaternion_rotate_vector_test.sv
// Self-checking testbench for quaternion_rotate_vector: directed and random requests, scoreboard.
module quaternion_rotate_vector_test;
  import qrv_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_REQUESTS = 1835;

  typedef struct {
    logic  inverse;
    quat_t qx;
    quat_t qy;
    quat_t qz;
    quat_t qw;
    vec_t  vx;
    vec_t  vy;
    vec_t  vz;
  } rotation_req_t;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    logic clipped;
  } rotated_t;

  class rotation_scoreboard;
    rotated_t expected_q[$];
    int errors;

    function longint mul_round(longint a, longint b);
      return (a * b + longint'(HALF)) >>> FRAC_W;
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = mul_round(a[1], b[2]) - mul_round(a[2], b[1]);
      c[1] = mul_round(a[2], b[0]) - mul_round(a[0], b[2]);
      c[2] = mul_round(a[0], b[1]) - mul_round(a[1], b[0]);
    endfunction

    function rotated_t rotate(rotation_req_t r);
      longint ax[3];
      longint v[3];
      longint c[3];
      longint t[3];
      longint u[3];
      longint w;
      longint s[3];
      longint vmax;
      longint vmin;
      rotated_t o;
      vmax = (longint'(1) << (VEC_W - 1)) - 1;
      vmin = -vmax - 1;
      ax[0] = r.qx;
      ax[1] = r.qy;
      ax[2] = r.qz;
      w = r.qw;
      v[0] = r.vx;
      v[1] = r.vy;
      v[2] = r.vz;
      if (r.inverse) begin
        for (int k = 0; k < 3; k++) ax[k] = -ax[k];
      end
      cross3(ax, v, c);
      for (int k = 0; k < 3; k++) t[k] = 2 * c[k];
      cross3(ax, t, u);
      o.clipped = 1'b0;
      for (int k = 0; k < 3; k++) begin
        s[k] = v[k] + mul_round(w, t[k]) + u[k];
        if (s[k] > vmax) begin
          s[k] = vmax;
          o.clipped = 1'b1;
        end else if (s[k] < vmin) begin
          s[k] = vmin;
          o.clipped = 1'b1;
        end
      end
      o.x = vec_t'(s[0]);
      o.y = vec_t'(s[1]);
      o.z = vec_t'(s[2]);
      return o;
    endfunction

    function void note_request(rotation_req_t r);
      expected_q.push_back(rotate(r));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(rotated_t got);
      rotated_t exp_r;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        exp_r = expected_q.pop_front();
        if (got.x !== exp_r.x)
          report($sformatf("out_x got %0d expected %0d", got.x, exp_r.x));
        if (got.y !== exp_r.y)
          report($sformatf("out_y got %0d expected %0d", got.y, exp_r.y));
        if (got.z !== exp_r.z)
          report($sformatf("out_z got %0d expected %0d", got.z, exp_r.z));
        if (got.clipped !== exp_r.clipped)
          report($sformatf("saturated got %b expected %b", got.clipped, exp_r.clipped));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int cycle_count = 0;
  int accepted = 0;
  bit long_hold_done = 0;
  rotation_scoreboard sb = new;

  qrv_req_if req_ch();
  qrv_res_if res_ch();

  quaternion_rotate_vector i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quaternion_rotate_vector_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(rotation_req_t'{req_ch.req_type, req_ch.quat_x, req_ch.quat_y,
                                        req_ch.quat_z, req_ch.quat_w, req_ch.vec_x,
                                        req_ch.vec_y, req_ch.vec_z});
        accepted++;
      end
      if (res_ch.valid && res_ch.ready)
        sb.check_result(rotated_t'{res_ch.out_x, res_ch.out_y, res_ch.out_z,
                                   res_ch.saturated});
    end
  end

  function automatic rotation_req_t make_request(int inv, int qx, int qy, int qz, int qw,
                                                 int vx, int vy, int vz);
    rotation_req_t r;
    r.inverse = 1'(inv);
    r.qx = quat_t'(qx);
    r.qy = quat_t'(qy);
    r.qz = quat_t'(qz);
    r.qw = quat_t'(qw);
    r.vx = vec_t'(vx);
    r.vy = vec_t'(vy);
    r.vz = vec_t'(vz);
    return r;
  endfunction

  function automatic vec_t random_coord(int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    return vec_t'(longint'($urandom_range(0, int'(2 * lim - 1))) - lim);
  endfunction

  function automatic rotation_req_t random_request();
    rotation_req_t r;
    real c[4];
    real mag;
    int sel;
    int bits;
    quat_t qpick[5] = '{quat_t'(-32768), quat_t'(32767), quat_t'(0), quat_t'(16384),
                        quat_t'(-16384)};
    vec_t vpick[5] = '{vec_t'(-8388608), vec_t'(8388607), vec_t'(0), vec_t'(1), vec_t'(-1)};
    sel = $urandom_range(0, 99);
    r.inverse = 1'($urandom_range(0, 1));
    if (sel < 70) begin
      // unit quaternion, so most results stay in range
      do begin
        mag = 0.0;
        for (int k = 0; k < 4; k++) begin
          c[k] = real'($urandom_range(0, 65536)) / 32768.0 - 1.0;
          mag += c[k] * c[k];
        end
        mag = $sqrt(mag);
      end while (mag < 0.05);
      r.qx = quat_t'($rtoi(c[0] / mag * 16384.0));
      r.qy = quat_t'($rtoi(c[1] / mag * 16384.0));
      r.qz = quat_t'($rtoi(c[2] / mag * 16384.0));
      r.qw = quat_t'($rtoi(c[3] / mag * 16384.0));
      bits = (sel < 55) ? $urandom_range(1, 24) : 24;
      r.vx = random_coord(bits);
      r.vy = random_coord(bits);
      r.vz = random_coord(bits);
    end else if (sel < 85) begin
      r.qx = quat_t'($urandom);
      r.qy = quat_t'($urandom);
      r.qz = quat_t'($urandom);
      r.qw = quat_t'($urandom);
      r.vx = vec_t'($urandom);
      r.vy = vec_t'($urandom);
      r.vz = vec_t'($urandom);
    end else begin
      r.qx = qpick[$urandom_range(0, 4)];
      r.qy = qpick[$urandom_range(0, 4)];
      r.qz = qpick[$urandom_range(0, 4)];
      r.qw = qpick[$urandom_range(0, 4)];
      r.vx = vpick[$urandom_range(0, 4)];
      r.vy = vpick[$urandom_range(0, 4)];
      r.vz = vpick[$urandom_range(0, 4)];
    end
    return r;
  endfunction

  task send_request(rotation_req_t r);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.inverse;
    req_ch.quat_x <= r.qx;
    req_ch.quat_y <= r.qy;
    req_ch.quat_z <= r.qz;
    req_ch.quat_w <= r.qw;
    req_ch.vec_x <= r.vx;
    req_ch.vec_y <= r.vy;
    req_ch.vec_z <= r.vz;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task idle_requests(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    int span;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int n = 0; n < span; n++) begin
        @(posedge clk);
        if (!long_hold_done && accepted >= 400) begin
          // long back-pressure so the pipeline fills and stalls requests
          long_hold_done = 1;
          res_ch.ready <= 1'b0;
          repeat (250) @(posedge clk);
        end
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (n % 3 != 2);
        endcase
      end
    end
  end

  initial begin
    rotation_req_t directed[$];
    int burst_left;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= 1'b0;
    req_ch.quat_x <= '0;
    req_ch.quat_y <= '0;
    req_ch.quat_z <= '0;
    req_ch.quat_w <= '0;
    req_ch.vec_x <= '0;
    req_ch.vec_y <= '0;
    req_ch.vec_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_request(0, 0, 0, 0, 16384, 1000, -2000, 3000));
    directed.push_back(make_request(1, 0, 0, 0, 16384, 1000, -2000, 3000));
    directed.push_back(make_request(0, 0, 0, 0, 0, 8388607, -8388608, 0));
    directed.push_back(make_request(0, 0, 0, 11585, 11585, 8388607, 0, 0));
    directed.push_back(make_request(1, 0, 0, 11585, 11585, 8388607, 0, 0));
    directed.push_back(make_request(0, 16384, 0, 0, 0, 0, 5000, 7000));
    // non-unit quaternions scale and clip
    directed.push_back(make_request(0, -32768, -32768, -32768, -32768,
                                    8388607, 8388607, 8388607));
    directed.push_back(make_request(1, -32768, -32768, -32768, -32768,
                                    -8388608, -8388608, -8388608));
    directed.push_back(make_request(1, -32768, 0, 0, 0, 0, 1000, 0));
    directed.push_back(make_request(0, 32767, 32767, 32767, 32767,
                                    -8388608, 8388607, -8388608));
    directed.push_back(make_request(0, 16384, 0, 0, 32767, 0, 4000000, 0));
    // rounding ties: 0.5 * 1 and 0.5 * -1
    directed.push_back(make_request(0, 8192, 0, 0, 8192, 0, 1, -1));
    directed.push_back(make_request(1, 0, 8192, -8192, 0, 1, -1, 1));
    directed.push_back(make_request(0, 12345, -23456, 3456, -4567, 0, 0, 0));
    directed.push_back(make_request(1, 32767, -32768, 0, -32768, -1, 1, 8388607));
    foreach (directed[k]) send_request(directed[k]);
    drain_results();

    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 900) begin
        drain_results();
      end else if (burst_left <= 0) begin
        idle_requests($urandom_range(1, 10));
        burst_left = $urandom_range(1, 40);
      end
      send_request(random_request());
      burst_left--;
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report("requests left without a result");

    if (sb.errors == 0)
      $display("quaternion_rotate_vector_test: done, clean");
    else
      $display("quaternion_rotate_vector_test: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/qrv_pkg.sv
hdl/qrv_req_if.sv
hdl/qrv_res_if.sv
hdl/quaternion_rotate_vector.sv
test/quaternion_rotate_vector_test.sv
